/* hw/rtl/modulated_position_generator_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the modulated position generator
// Concurrent checks on the clock and the active-low synchronous reset.
// ----------------------------------------------------------------------------
`ifndef MODULATED_POSITION_GENERATOR_TOP_ASSERT_SVH
`define MODULATED_POSITION_GENERATOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define MPG_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`define MPG_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
`else
`define MPG_ASSERT_NEXT(lbl, pre, post, msg)
`define MPG_ASSERT_SAME(lbl, pre, post, msg)
`endif
`endif

/* hw/rtl/mpg_pkg.sv */
// ----------------------------------------------------------------------------
// Modulated position generator package
// Field widths, register indexes, defaults and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package mpg_pkg;

    localparam int MPG_ANGLE_BITS        = 16;
    localparam int MPG_CORDIC_ITERATIONS = 16;

    localparam int MPG_CFG_IDX_W  = 3;
    localparam int MPG_CFG_DATA_W = 32;
    localparam int MPG_POS_W      = 25;

    localparam logic [MPG_CFG_IDX_W-1:0] REG_RADIUS       = 3'd0;
    localparam logic [MPG_CFG_IDX_W-1:0] REG_BASE_AZIMUTH = 3'd1;
    localparam logic [MPG_CFG_IDX_W-1:0] REG_ELEVATION    = 3'd2;
    localparam logic [MPG_CFG_IDX_W-1:0] REG_PHASE_STEP   = 3'd3;
    localparam logic [MPG_CFG_IDX_W-1:0] REG_MOD_DEPTH    = 3'd4;

    localparam logic [23:0] RADIUS_RESET     = 24'd65536;
    localparam logic [31:0] PHASE_STEP_RESET = 32'd89478;

    // CORDIC gain compensation, Q30.
    localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;

    // Arctangent of 2^-i in 2^32 units per turn.
    function automatic logic [31:0] f_atan(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/mpg_if.sv */
// ----------------------------------------------------------------------------
// Modulated position generator channels
// Tick input, position output and configuration write channels.
// ----------------------------------------------------------------------------
interface mpg_in_if;
    logic        valid;
    logic        ready;
    logic        block_start;
    logic [31:0] frame_position;
    logic        transport_running;
    modport source (output valid, block_start, frame_position, transport_running,
                    input ready);
    modport sink   (input valid, block_start, frame_position, transport_running,
                    output ready);
endinterface

interface mpg_out_if;
    logic               valid;
    logic               ready;
    logic signed [24:0] pos_x;
    logic signed [24:0] pos_y;
    logic signed [24:0] pos_z;
    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface mpg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/modulated_position_generator_top.sv */
// ----------------------------------------------------------------------------
// Modulated position generator
// Sine LFO on the azimuth, spherical to Cartesian conversion by CORDIC.
// ----------------------------------------------------------------------------
// One tick in gives one saturated Q8.16 position out. A tick is processed
// alone; when block_start reloads the phase, the phase product is first
// formed bit-serially, one multiplier bit per cycle. The single shared CORDIC
// unit, one iteration per cycle, runs three rotations in turn: the
// modulating sine, the elevation and the azimuth. A finished position sits
// in an output register, so the next tick is accepted while it waits.
// Configuration writes take effect at once.
`include "modulated_position_generator_top_assert.svh"

module modulated_position_generator_top #(
    parameter int ANGLE_BITS        = mpg_pkg::MPG_ANGLE_BITS,
    parameter int CORDIC_ITERATIONS = mpg_pkg::MPG_CORDIC_ITERATIONS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mpg_in_if.sink         i_in,
    mpg_out_if.source      o_out,
    mpg_cfg_if.sink        i_cfg
);
    import mpg_pkg::*;

    localparam int XW = 36;
    localparam int ZW = 34;
    localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
    localparam logic [4:0]  LAST_ITER  = 5'(CORDIC_ITERATIONS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_ITER = 3'd3;
    localparam logic [2:0] S_POST = 3'd4;
    localparam logic [2:0] S_OFF  = 3'd5;

    localparam logic [1:0] PASS_SIN  = 2'd0;
    localparam logic [1:0] PASS_ELEV = 2'd1;
    localparam logic [1:0] PASS_AZ   = 2'd2;

    localparam logic signed [24:0] OUT_MAX = 25'sd16777215;

    function automatic logic signed [24:0] f_to_out(input logic signed [XW-1:0] v);
        logic signed [XW:0] r;
        logic signed [XW:0] q;
        r = (XW+1)'(v) + 37'sd128;
        q = r >>> 8;
        if (q > 37'sd16777215) begin
            return OUT_MAX;
        end else if (q < -37'sd16777215) begin
            return -OUT_MAX;
        end
        return q[24:0];
    endfunction

    logic [23:0]        r_radius;
    logic [15:0]        r_base;
    logic signed [15:0] r_elev;
    logic [31:0]        r_step;
    logic signed [15:0] r_depth;
    logic [31:0]        r_phase;

    logic [2:0]         r_state;
    logic [4:0]         r_cnt;
    logic [1:0]         r_pass;
    logic               r_trans;
    logic [31:0]        r_mcand;
    logic [31:0]        r_mplier;
    logic [31:0]        r_macc;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic               r_neg;
    logic signed [15:0] r_sin;
    logic [15:0]        r_az;
    logic signed [XW-1:0] r_h;
    logic signed [XW-1:0] r_zc;

    logic               r_out_valid;
    logic signed [24:0] r_px;
    logic signed [24:0] r_py;
    logic signed [24:0] r_pz;

    logic [31:0]        n_macc;
    logic signed [15:0] el_sat;
    logic [31:0]        angle;
    logic [31:0]        t_q;
    logic               flip;
    logic signed [ZW-1:0] z0;
    logic signed [XW-1:0] mult_in;
    logic signed [XW+30:0] prod;
    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] at;
    logic signed [XW-1:0] cos_v;
    logic signed [XW-1:0] sin_v;
    logic signed [XW:0]   sin_r;
    logic signed [15:0]   sin_sat;
    logic signed [31:0]   off_prod;
    logic signed [31:0]   off_v;
    logic                 in_xfer;
    logic                 out_load;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.pos_x = r_px;
    assign o_out.pos_y = r_py;
    assign o_out.pos_z = r_pz;

    assign in_xfer = i_in.valid && i_in.ready;

    always_comb begin
        n_macc = r_macc + (r_mplier[0] ? r_mcand : 32'd0);

        if (r_elev > 16'sd16384) begin
            el_sat = 16'sd16384;
        end else if (r_elev < -16'sd16384) begin
            el_sat = -16'sd16384;
        end else begin
            el_sat = r_elev;
        end

        unique case (r_pass)
            PASS_SIN:  angle = r_phase;
            PASS_ELEV: angle = {el_sat, 16'h0000};
            PASS_AZ:   angle = {r_az, 16'h0000};
            default:   angle = r_phase;
        endcase
        t_q = angle & ANGLE_MASK;
        // Second and third quadrants rotate by a half turn and negate after.
        flip = t_q[31] ^ t_q[30];
        z0 = ZW'($signed({t_q[31] ^ flip, t_q[30:0]}));

        unique case (r_pass)
            PASS_SIN:  mult_in = XW'(64'sd1073741824);
            PASS_ELEV: mult_in = $signed({4'b0000, r_radius, 8'h00});
            PASS_AZ:   mult_in = r_h;
            default:   mult_in = r_h;
        endcase
        prod = mult_in * GAIN_Q30;
        x0 = prod[XW+29:30];

        dx = r_y >>> r_cnt;
        dy = r_x >>> r_cnt;
        at = $signed({2'b00, f_atan(r_cnt)});

        cos_v = r_neg ? -r_x : r_x;
        sin_v = r_neg ? -r_y : r_y;
        sin_r = ((XW+1)'(sin_v) + 37'sd16384) >>> 15;
        if (sin_r > 37'sd32767) begin
            sin_sat = 16'sh7FFF;
        end else if (sin_r < -37'sd32768) begin
            sin_sat = -16'sh8000;
        end else begin
            sin_sat = sin_r[15:0];
        end

        off_prod = r_depth * r_sin;
        off_v = off_prod >>> 15;

        out_load = (r_state == S_POST) && (r_pass == PASS_AZ) &&
                   (!r_out_valid || o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= RADIUS_RESET;
            r_base      <= 16'h0000;
            r_elev      <= 16'sh0000;
            r_step      <= PHASE_STEP_RESET;
            r_depth     <= 16'sh0000;
            r_phase     <= 32'h0;
            r_state     <= S_IDLE;
            r_cnt       <= 5'd0;
            r_pass      <= PASS_SIN;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    REG_RADIUS:       r_radius <= i_cfg.data[23:0];
                    REG_BASE_AZIMUTH: r_base   <= i_cfg.data[15:0];
                    REG_ELEVATION:    r_elev   <= $signed(i_cfg.data[15:0]);
                    REG_PHASE_STEP:   r_step   <= i_cfg.data;
                    REG_MOD_DEPTH:    r_depth  <= $signed(i_cfg.data[15:0]);
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_trans <= i_in.transport_running;
                        r_pass  <= PASS_SIN;
                        if (i_in.block_start) begin
                            r_mcand  <= r_step;
                            r_mplier <= i_in.frame_position;
                            r_macc   <= 32'h0;
                            r_cnt    <= 5'd0;
                            r_state  <= S_MUL;
                        end else begin
                            r_state <= S_PREP;
                        end
                    end
                end
                S_MUL: begin
                    // One multiplier bit per cycle; only the low 32 bits are kept.
                    r_macc   <= n_macc;
                    r_mcand  <= {r_mcand[30:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[31:1]};
                    r_cnt    <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_phase <= n_macc;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_x     <= x0;
                    r_y     <= '0;
                    r_z     <= z0;
                    r_neg   <= flip;
                    r_cnt   <= 5'd0;
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    if (!r_z[ZW-1]) begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + at;
                    end
                    if (r_cnt == LAST_ITER) begin
                        r_state <= S_POST;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_POST: begin
                    unique case (r_pass)
                        PASS_SIN: begin
                            r_sin   <= sin_sat;
                            r_state <= S_OFF;
                        end
                        PASS_ELEV: begin
                            r_h     <= cos_v;
                            r_zc    <= sin_v;
                            r_pass  <= PASS_AZ;
                            r_state <= S_PREP;
                        end
                        default: begin
                            if (out_load) begin
                                r_px <= f_to_out(cos_v);
                                r_py <= f_to_out(sin_v);
                                r_pz <= f_to_out(r_zc);
                                if (r_trans) begin
                                    r_phase <= r_phase + r_step;
                                end
                                r_state <= S_IDLE;
                            end
                        end
                    endcase
                end
                S_OFF: begin
                    r_az    <= r_base + off_v[15:0];
                    r_pass  <= PASS_ELEV;
                    r_state <= S_PREP;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `MPG_ASSERT_NEXT(a_busy_after_tick, in_xfer, r_state != S_IDLE, "tick did not start work")
    `MPG_ASSERT_SAME(a_iter_bound, r_state == S_ITER, r_cnt <= LAST_ITER, "iteration overrun")
    `MPG_ASSERT_SAME(a_valid_from_post, $rose(r_out_valid), $past(r_state) == S_POST, "stray result")

endmodule

/* tb/sv/tb_modulated_position_generator_top.sv */
// ----------------------------------------------------------------------------
// Modulated position generator testbench
// Drives sample ticks and register writes, predicts every position with a
// fixed-point model of the LFO and the CORDIC rotations, and compares each
// transfer on the position channel against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_modulated_position_generator_top;
    import mpg_pkg::*;

    typedef struct packed {
        logic        block_start;
        logic [31:0] frame_position;
        logic        transport_running;
    } t_tick;

    typedef struct packed {
        logic signed [24:0] x;
        logic signed [24:0] y;
        logic signed [24:0] z;
    } t_pos;

    localparam longint POS_LIMIT = 64'sd16777215;
    localparam int     WATCHDOG  = 20000;

    logic i_clk;
    logic i_rst_n;

    mpg_in_if  tick_ch ();
    mpg_out_if pos_ch ();
    mpg_cfg_if cfg_ch ();

    modulated_position_generator_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_ch.sink),
        .o_out   (pos_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Predictor state.
    logic [23:0] radius_q;
    logic [15:0] base_az_q;
    logic [15:0] elev_q;
    logic [31:0] step_q;
    logic [15:0] depth_q;
    logic [31:0] lfo_phase;

    t_tick pending_ticks[$];
    t_pos  expected_pos[$];

    int  errors;
    int  idle_stall;
    int  quiet_cycles;
    bit  timed_out;
    bit  cfg_busy;
    logic [2:0]  cfg_idx_next;
    logic [31:0] cfg_data_next;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint floor_shift(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic logic [31:0] clip_angle(input logic [31:0] a);
        return a & (32'hFFFF_FFFF << (32 - MPG_ANGLE_BITS));
    endfunction

    task automatic cordic_rotate(input longint mag, input logic [31:0] ang,
                                 output longint cos_o, output longint sin_o);
        logic [31:0] t;
        bit     flip;
        longint cx, cy, cz, dx, dy;
        t = ang;
        flip = 1'b0;
        if (t[31:30] == 2'd1 || t[31:30] == 2'd2) begin
            t = t - 32'h8000_0000;
            flip = 1'b1;
        end
        cz = longint'($signed(t));
        cx = floor_shift(mag * 64'sd652032874, 30);
        cy = 0;
        for (int i = 0; i < MPG_CORDIC_ITERATIONS; i++) begin
            dx = floor_shift(cy, i);
            dy = floor_shift(cx, i);
            if (cz >= 0) begin
                cx = cx - dx;
                cy = cy + dy;
                cz = cz - longint'(f_atan(i[4:0]));
            end else begin
                cx = cx + dx;
                cy = cy - dy;
                cz = cz + longint'(f_atan(i[4:0]));
            end
        end
        cos_o = flip ? -cx : cx;
        sin_o = flip ? -cy : cy;
    endtask

    function automatic logic signed [24:0] round_to_pos(input longint v);
        longint r;
        r = floor_shift(v + 128, 8);
        if (r > POS_LIMIT) r = POS_LIMIT;
        if (r < -POS_LIMIT) r = -POS_LIMIT;
        return r[24:0];
    endfunction

    task automatic predict_position(input t_tick tk);
        longint c, s, sin15, offset, el, h, zc, xc, yc;
        logic [15:0] az;
        logic [63:0] prod;
        t_pos p;
        if (tk.block_start) begin
            prod = 64'(step_q) * 64'(tk.frame_position);
            lfo_phase = prod[31:0];
        end
        cordic_rotate(64'sd1 <<< 30, clip_angle(lfo_phase), c, s);
        sin15 = floor_shift(s + (64'sd1 <<< 14), 15);
        if (sin15 > 32767) sin15 = 32767;
        if (sin15 < -32768) sin15 = -32768;
        offset = floor_shift(longint'($signed(depth_q)) * sin15, 15);
        az = base_az_q + offset[15:0];
        el = longint'($signed(elev_q));
        if (el > 16384) el = 16384;
        if (el < -16384) el = -16384;
        cordic_rotate(longint'(radius_q) <<< 8, clip_angle({el[15:0], 16'h0}), h, zc);
        cordic_rotate(h, clip_angle({az, 16'h0}), xc, yc);
        p.x = round_to_pos(xc);
        p.y = round_to_pos(yc);
        p.z = round_to_pos(zc);
        expected_pos.push_back(p);
        if (tk.transport_running) lfo_phase = lfo_phase + step_q;
    endtask

    // Tick driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_ch.valid <= 1'b0;
        end else if (!tick_ch.valid || tick_ch.ready) begin
            if (tick_ch.valid) begin
                predict_position(pending_ticks.pop_front());
            end
            if (pending_ticks.size() > 0 && (idle_stall != 0 || $urandom_range(99) >= 27))
            begin
                tick_ch.valid             <= 1'b1;
                tick_ch.block_start       <= pending_ticks[0].block_start;
                tick_ch.frame_position    <= pending_ticks[0].frame_position;
                tick_ch.transport_running <= pending_ticks[0].transport_running;
            end else begin
                tick_ch.valid <= 1'b0;
            end
        end
    end

    // Position monitor and receiver stalls.
    always @(posedge i_clk) begin
        t_pos e;
        if (!i_rst_n) begin
            pos_ch.ready <= 1'b0;
        end else begin
            if (pos_ch.valid && pos_ch.ready) begin
                if (expected_pos.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected position x=%0d y=%0d z=%0d",
                                 pos_ch.pos_x, pos_ch.pos_y, pos_ch.pos_z);
                end else begin
                    e = expected_pos.pop_front();
                    if (e.x !== pos_ch.pos_x || e.y !== pos_ch.pos_y ||
                        e.z !== pos_ch.pos_z) begin
                        errors++;
                        if (errors <= 10)
                            $display("position mismatch: exp %0d %0d %0d got %0d %0d %0d",
                                     e.x, e.y, e.z, pos_ch.pos_x, pos_ch.pos_y,
                                     pos_ch.pos_z);
                    end
                end
            end
            pos_ch.ready <= (idle_stall != 0) || ($urandom_range(99) >= 27);
        end
    end

    // Register write channel; the predictor takes the value on the transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_ch.valid <= 1'b0;
        end else if (cfg_ch.valid && cfg_ch.ready) begin
            case (cfg_ch.index)
                REG_RADIUS:       radius_q  = cfg_ch.data[23:0];
                REG_BASE_AZIMUTH: base_az_q = cfg_ch.data[15:0];
                REG_ELEVATION:    elev_q    = cfg_ch.data[15:0];
                REG_PHASE_STEP:   step_q    = cfg_ch.data;
                REG_MOD_DEPTH:    depth_q   = cfg_ch.data[15:0];
                default: ;
            endcase
            cfg_ch.valid <= 1'b0;
            cfg_busy = 1'b0;
        end else if (cfg_busy && !cfg_ch.valid) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= cfg_idx_next;
            cfg_ch.data  <= cfg_data_next;
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((tick_ch.valid && tick_ch.ready) || (pos_ch.valid && pos_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG && !timed_out) begin
            timed_out = 1'b1;
            $display("** modulated_position_generator_top: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_idx_next  = idx;
        cfg_data_next = val;
        cfg_busy      = 1'b1;
        while (cfg_busy) @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending_ticks.size() > 0 || tick_ch.valid || expected_pos.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic add_tick(input bit bs, input logic [31:0] fp, input bit tr);
        t_tick t;
        t.block_start = bs;
        t.frame_position = fp;
        t.transport_running = tr;
        pending_ticks.push_back(t);
    endtask

    task automatic random_ticks(input int n);
        for (int i = 0; i < n; i++) begin
            add_tick($urandom_range(99) < 20, $urandom, $urandom_range(99) < 80);
        end
    endtask

    task automatic random_config();
        write_reg(REG_RADIUS, ($urandom_range(3) == 0) ? $urandom : $urandom_range(262143));
        write_reg(REG_BASE_AZIMUTH, $urandom);
        write_reg(REG_ELEVATION, $urandom);
        write_reg(REG_PHASE_STEP, $urandom);
        write_reg(REG_MOD_DEPTH, $urandom);
    endtask

    initial begin
        errors = 0;
        timed_out = 1'b0;
        cfg_busy = 1'b0;
        idle_stall = 0;
        quiet_cycles = 0;
        radius_q = RADIUS_RESET;
        base_az_q = '0;
        elev_q = '0;
        step_q = PHASE_STEP_RESET;
        depth_q = '0;
        lfo_phase = '0;
        i_rst_n = 1'b0;
        tick_ch.valid = 1'b0;
        tick_ch.block_start = 1'b0;
        tick_ch.frame_position = '0;
        tick_ch.transport_running = 1'b0;
        pos_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Ticks before any block start run from the reset phase.
        add_tick(1'b0, 32'hFFFF_FFFF, 1'b1);
        add_tick(1'b0, 32'h0, 1'b0);
        add_tick(1'b0, 32'h0, 1'b1);
        drain();

        // Extremes: full radius at the clamped full elevation, full depth.
        write_reg(REG_RADIUS, 32'h00FF_FFFF);
        write_reg(REG_MOD_DEPTH, 32'h0000_7FFF);
        write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(REG_BASE_AZIMUTH, 32'h0000_FFFF);
        write_reg(REG_ELEVATION, 32'h0000_7FFF);
        write_reg(3'd7, 32'hDEAD_BEEF);
        add_tick(1'b1, 32'hFFFF_FFFF, 1'b1);
        add_tick(1'b0, 32'h0, 1'b1);
        add_tick(1'b1, 32'h0000_0001, 1'b0);
        add_tick(1'b0, 32'h0, 1'b0);
        add_tick(1'b1, 32'h8000_0000, 1'b1);
        drain();

        write_reg(REG_ELEVATION, 32'h0000_8000);
        write_reg(REG_MOD_DEPTH, 32'h0000_8000);
        write_reg(REG_BASE_AZIMUTH, 32'h0000_4000);
        write_reg(REG_PHASE_STEP, 32'h4000_0000);
        add_tick(1'b1, 32'h0000_0001, 1'b1);
        add_tick(1'b0, 32'h0, 1'b1);
        add_tick(1'b0, 32'h0, 1'b1);
        add_tick(1'b0, 32'h0, 1'b1);
        drain();

        write_reg(REG_RADIUS, 32'h0);
        write_reg(REG_ELEVATION, 32'h0000_C000);
        write_reg(REG_PHASE_STEP, 32'h0);
        add_tick(1'b1, 32'h5555_5555, 1'b1);
        add_tick(1'b0, 32'hAAAA_AAAA, 1'b0);
        drain();

        // Random part: a no-stall stretch first, then random idling.
        idle_stall = 1;
        random_config();
        random_ticks(60);
        drain();
        idle_stall = 0;
        for (int ph = 0; ph < 6; ph++) begin
            random_config();
            random_ticks(57);
            drain();
        end

        if (errors == 0)
            $display("** modulated_position_generator_top: PASSED **");
        else
            $display("** modulated_position_generator_top: FAILED **");
        $finish;
    end
endmodule
